// ===== hw/rtl/frwl_pkg.sv =====
// Shared constants, types and the row hash of the fixed-window rate limiter.
`timescale 1ns / 1ps

package frwl_pkg;

  // Field widths
  localparam int KEY_W   = 32;
  localparam int TIME_W  = 32;
  localparam int COUNT_W = 32;
  localparam int CFG_W   = 32;

  // Client table, a power of two so the row is the low hash bits
  localparam int TABLE_DEPTH = 1024;
  localparam int ROW_W       = $clog2(TABLE_DEPTH);

  // Job queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [31:0]        HASH_SEED            = 32'd5381;
  localparam logic [CFG_W-1:0]   MAX_REQUESTS_RESET   = 32'd5;
  localparam logic [CFG_W-1:0]   WINDOW_SECONDS_RESET = 32'd1;
  localparam logic [COUNT_W-1:0] COUNT_MAX            = '1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_REQUESTS   = 1'b0,
    CFG_WINDOW_SECONDS = 1'b1
  } cfg_idx_e;

  typedef logic [ROW_W-1:0] row_t;

  // One classified request waiting for the table
  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    row_t              row;
  } job_t;

  // One table row
  typedef struct packed {
    logic               valid;
    logic [KEY_W-1:0]   tag;
    logic [TIME_W-1:0]  win_begin;
    logic [COUNT_W-1:0] win_count;
  } entry_t;

  typedef enum logic [2:0] {
    B_CLEAR,
    B_IDLE,
    B_READ,
    B_CHECK,
    B_WRITE
  } back_state_e;

  // djb2 over the key bytes, most significant first; only the row bits are kept,
  // which is exact because the low bits of a sum and product depend only on low bits
  function automatic row_t row_of(input logic [KEY_W-1:0] key);
    row_t h;
    h = HASH_SEED[ROW_W-1:0];
    for (int i = 3; i >= 0; i--) begin
      h = (h << 5) + h + ROW_W'(key[8*i +: 8]);
    end
    return h;
  endfunction

endpackage

// ===== hw/rtl/frwl_req_if.sv =====
// Request channel: client key and current time.
`timescale 1ns / 1ps

interface frwl_req_if
  import frwl_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [KEY_W-1:0]  client_key;
  logic [TIME_W-1:0] now_seconds;

  modport source (output valid, client_key, now_seconds, input ready);
  modport sink   (input valid, client_key, now_seconds, output ready);
endinterface

// ===== hw/rtl/frwl_rsp_if.sv =====
// Response channel: limit decision and window count.
`timescale 1ns / 1ps

interface frwl_rsp_if
  import frwl_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               limited;
  logic [COUNT_W-1:0] request_count;

  modport source (output valid, limited, request_count, input ready);
  modport sink   (input valid, limited, request_count, output ready);
endinterface

// ===== hw/rtl/frwl_front.sv =====
// Front end: accepts request words and tags each with its table row.
`timescale 1ns / 1ps

module frwl_front
  import frwl_pkg::*;
(
  frwl_req_if.sink req_i,
  input  logic     enable_i,
  input  logic     q_full_i,
  output logic     q_push_o,
  output job_t     q_job_o
);

  // Take a word only once the table is cleared and the queue has room
  assign req_i.ready = enable_i && !q_full_i;
  assign q_push_o    = req_i.valid && req_i.ready;

  // Hash the key into a row
  always_comb begin
    q_job_o.key = req_i.client_key;
    q_job_o.now = req_i.now_seconds;
    q_job_o.row = row_of(req_i.client_key);
  end

endmodule

// ===== hw/rtl/frwl_fifo.sv =====
// Short job queue between the front end and the table engine.
`timescale 1ns / 1ps

module frwl_fifo
  import frwl_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t job_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t job_o
);

  job_t                slot_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = slot_q[rd_ptr_q];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Store the pushed word
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= job_i;
    end
  end

endmodule

// ===== hw/rtl/frwl_back.sv =====
// Table engine: clears the client table, then reads, updates and writes one row per job.
`timescale 1ns / 1ps

module frwl_back
  import frwl_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              job_valid_i,
  input  job_t              job_i,
  output logic              job_pop_o,
  input  logic [CFG_W-1:0]  max_requests_i,
  input  logic [CFG_W-1:0]  window_seconds_i,
  output logic              clr_done_o,
  frwl_rsp_if.source        rsp_o
);

  back_state_e state_q, state_d;
  row_t        clr_idx_q;

  job_t   job_q;
  entry_t mem_q [TABLE_DEPTH];
  entry_t rdata_q;

  logic               mem_we;
  row_t               mem_waddr;
  entry_t             mem_wdata;
  logic               out_load;

  logic [TIME_W-1:0]  begin_q;
  logic [COUNT_W-1:0] base_q;

  logic               hit;
  logic [TIME_W-1:0]  elapsed;
  logic               restart;

  logic               sat;
  logic [COUNT_W-1:0] new_count;
  logic               new_limited;

  logic               out_valid_q;
  logic               out_limited_q;
  logic [COUNT_W-1:0] out_count_q;
  logic               out_free;

  assign out_free   = !out_valid_q || rsp_o.ready;
  assign clr_done_o = (state_q != B_CLEAR);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_CLEAR: if (clr_idx_q == ROW_W'(TABLE_DEPTH - 1)) state_d = B_IDLE;
      B_IDLE:  if (job_valid_i) state_d = B_READ;
      B_READ:  state_d = B_CHECK;
      B_CHECK: state_d = B_WRITE;
      B_WRITE: if (out_free) state_d = B_IDLE;
      default: state_d = B_CLEAR;
    endcase
  end

  // Decide the new count and limit flag from the checked row
  always_comb begin
    sat         = (base_q == COUNT_MAX);
    new_count   = sat ? base_q : base_q + 1'b1;
    new_limited = sat ? (max_requests_i != COUNT_MAX) : (base_q >= max_requests_i);
  end

  // State outputs
  always_comb begin
    job_pop_o = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = job_q.row;
    mem_wdata = '0;
    out_load  = 1'b0;
    case (state_q)
      B_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_idx_q;
      end
      B_IDLE: begin
        job_pop_o = job_valid_i;
      end
      B_WRITE: begin
        if (out_free) begin
          mem_we              = 1'b1;
          mem_wdata.valid     = 1'b1;
          mem_wdata.tag       = job_q.key;
          mem_wdata.win_begin = begin_q;
          mem_wdata.win_count = new_count;
          out_load            = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= B_CLEAR;
      clr_idx_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLEAR) begin
        clr_idx_q <= clr_idx_q + 1'b1;
      end
    end
  end

  // Hold the job being served
  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
  end

  // Client table: one write port, one registered read of the current row
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[job_q.row];
  end

  // Check tag and window age
  always_comb begin
    hit     = rdata_q.valid && (rdata_q.tag == job_q.key);
    elapsed = job_q.now - rdata_q.win_begin;
    restart = !hit || (elapsed >= window_seconds_i);
  end

  always_ff @(posedge clk_i) begin
    if (state_q == B_CHECK) begin
      begin_q <= restart ? job_q.now : rdata_q.win_begin;
      base_q  <= restart ? '0 : rdata_q.win_count;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_limited_q <= new_limited;
      out_count_q   <= new_count;
    end
  end

  assign rsp_o.valid         = out_valid_q;
  assign rsp_o.limited       = out_limited_q;
  assign rsp_o.request_count = out_count_q;

endmodule

// ===== hw/rtl/fixed_window_rate_limiter_top.sv =====
// Top level of the fixed-window rate limiter.
`timescale 1ns / 1ps

// Per-client fixed-window limiter over a 1024-row direct-mapped table. After
// reset the table is swept clear, one row per cycle; no request word is
// taken until the sweep ends (configuration writes are taken at any time).
// Each request is hashed in the front end and queued; the table engine then
// takes it through four steps (dequeue, table read, tag and window check,
// table write with result) and takes no new request until that write is done;
// the write waits while the previous result has not been taken.
// A two-entry queue and a registered result let requests arrive while an
// earlier result waits to be taken.
module fixed_window_rate_limiter_top
  import frwl_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  frwl_req_if.sink             req_i,
  frwl_rsp_if.source           rsp_o
);

  logic [CFG_W-1:0] max_requests_q;
  logic [CFG_W-1:0] window_seconds_q;

  logic clr_done;
  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_valid;
  job_t q_in;
  job_t q_out;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_requests_q   <= MAX_REQUESTS_RESET;
      window_seconds_q <= WINDOW_SECONDS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MAX_REQUESTS:   max_requests_q   <= cfg_data_i;
        CFG_WINDOW_SECONDS: window_seconds_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  frwl_front u_front (
    .req_i    (req_i),
    .enable_i (clr_done),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_job_o  (q_in)
  );

  frwl_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .job_i   (q_in),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .job_o   (q_out)
  );

  frwl_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .job_valid_i      (q_valid),
    .job_i            (q_out),
    .job_pop_o        (q_pop),
    .max_requests_i   (max_requests_q),
    .window_seconds_i (window_seconds_q),
    .clr_done_o       (clr_done),
    .rsp_o            (rsp_o)
  );

  // No word enters before the table sweep is done
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |-> clr_done)
    else $error("request word taken during table clear");

  // Never push into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_push |-> !q_full)
    else $error("job queue overflow");

  // Never dequeue from an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("job queue underflow");

  // Every result counts at least the request itself
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> (rsp_o.request_count != '0))
    else $error("result with zero request count");

endmodule
